// ===== hw/rtl/mmad_pkg.sv =====
// Shared codes, window table and stage payload types for the address decoder.
package mmad_pkg;

	// Access kind codes carried on the input tuser.
	localparam logic [2:0] FUNC_LOAD8   = 3'd0;
	localparam logic [2:0] FUNC_LOAD16  = 3'd1;
	localparam logic [2:0] FUNC_LOAD32  = 3'd2;
	localparam logic [2:0] FUNC_STORE8  = 3'd3;
	localparam logic [2:0] FUNC_STORE16 = 3'd4;
	localparam logic [2:0] FUNC_STORE32 = 3'd5;

	// Target codes; each also indexes the window table.
	localparam logic [3:0] TGT_BIOS     = 4'd0;
	localparam logic [3:0] TGT_RAM      = 4'd1;
	localparam logic [3:0] TGT_IRQ      = 4'd2;
	localparam logic [3:0] TGT_DMA      = 4'd3;
	localparam logic [3:0] TGT_GPU      = 4'd4;
	localparam logic [3:0] TGT_TIMERS   = 4'd5;
	localparam logic [3:0] TGT_SPU      = 4'd6;
	localparam logic [3:0] TGT_EXP1     = 4'd7;
	localparam logic [3:0] TGT_EXP2     = 4'd8;
	localparam logic [3:0] TGT_MEMCTL   = 4'd9;
	localparam logic [3:0] TGT_RAMSIZE  = 4'd10;
	localparam logic [3:0] TGT_CACHECTL = 4'd11;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNALIGNED = 3'd1;
	localparam logic [2:0] ST_UNMAPPED  = 3'd2;
	localparam logic [2:0] ST_BADSUB    = 3'd3;
	localparam logic [2:0] ST_BADBASE   = 3'd4;

	localparam int NUM_WINDOWS = 12;

	// Segment masks applied by the top three address bits.
	localparam logic [31:0] SEG_MASK_KSEG0 = 32'h7FFF_FFFF;
	localparam logic [31:0] SEG_MASK_KSEG1 = 32'h1FFF_FFFF;

	// Expected bases written to the memory-control window.
	localparam logic [31:0] MEMCTL_BASE_EXP1 = 32'h1F00_0000;
	localparam logic [31:0] MEMCTL_BASE_EXP2 = 32'h1F80_2000;
	localparam logic [7:0]  EXP1_READ_VALUE  = 8'hFF;

	// Window start and length, indexed by target code.
	localparam logic [31:0] WIN_START [NUM_WINDOWS] = '{
		32'h1FC0_0000, 32'h0000_0000, 32'h1F80_1070, 32'h1F80_1080,
		32'h1F80_1810, 32'h1F80_1100, 32'h1F80_1C00, 32'h1F00_0000,
		32'h1F80_2000, 32'h1F80_1000, 32'h1F80_1060, 32'hFFFE_0130
	};
	localparam logic [31:0] WIN_LEN [NUM_WINDOWS] = '{
		32'h0008_0000, 32'h0020_0000, 32'd8, 32'h80,
		32'd8, 32'd48, 32'd640, 32'h0008_0000,
		32'd66, 32'd36, 32'd4, 32'd4
	};

	// Set of windows that each access kind may reach.
	function automatic logic [NUM_WINDOWS-1:0] kind_windows(input logic [2:0] kind);
		logic [NUM_WINDOWS-1:0] m;
		m = '0;
		unique case (kind)
			FUNC_LOAD8: begin
				m[TGT_BIOS] = 1'b1; m[TGT_RAM] = 1'b1; m[TGT_EXP1] = 1'b1;
			end
			FUNC_LOAD16: begin
				m[TGT_RAM] = 1'b1; m[TGT_IRQ] = 1'b1; m[TGT_SPU] = 1'b1;
			end
			FUNC_LOAD32: begin
				m[TGT_BIOS] = 1'b1; m[TGT_RAM] = 1'b1; m[TGT_IRQ] = 1'b1;
				m[TGT_DMA] = 1'b1; m[TGT_GPU] = 1'b1; m[TGT_TIMERS] = 1'b1;
			end
			FUNC_STORE8: begin
				m[TGT_RAM] = 1'b1; m[TGT_EXP2] = 1'b1;
			end
			FUNC_STORE16: begin
				m[TGT_RAM] = 1'b1; m[TGT_IRQ] = 1'b1; m[TGT_TIMERS] = 1'b1;
				m[TGT_SPU] = 1'b1;
			end
			FUNC_STORE32: begin
				m[TGT_RAM] = 1'b1; m[TGT_IRQ] = 1'b1; m[TGT_DMA] = 1'b1;
				m[TGT_GPU] = 1'b1; m[TGT_TIMERS] = 1'b1; m[TGT_MEMCTL] = 1'b1;
				m[TGT_RAMSIZE] = 1'b1; m[TGT_CACHECTL] = 1'b1;
			end
			default: m = '0;
		endcase
		return m;
	endfunction

	// Payload after alignment check and segment stripping.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] phys;
		logic [31:0] wdata;
		logic        unaligned;
	} align_t;

	// Payload after window matching.
	typedef struct packed {
		logic [NUM_WINDOWS-1:0] hit;
		logic [31:0]            phys;
		logic [31:0]            wdata;
		logic                   unaligned;
	} match_t;

	// Result transaction, first field in the highest bits.
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  constant_data;
		logic        absorbed;
		logic [1:0]  sub_register;
		logic [2:0]  dma_group;
		logic [20:0] window_offset;
		logic [3:0]  target;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/mmad_align.sv =====
// First stage: alignment check and segment stripping of the address.
module mmad_align
	import mmad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        valid_s1,
	output align_t      data_s1,
	input  logic        out_ready
);

	align_t nxt;

	// Alignment rules per access size and the region mask.
	always_comb begin
		nxt.kind      = func;
		nxt.wdata     = write_data;
		nxt.unaligned = (((func == FUNC_LOAD16) || (func == FUNC_STORE16)) && address[0]) ||
			(((func == FUNC_LOAD32) || (func == FUNC_STORE32)) && (address[1:0] != 2'b00));
		unique case (address[31:29])
			3'd4:    nxt.phys = address & SEG_MASK_KSEG0;
			3'd5:    nxt.phys = address & SEG_MASK_KSEG1;
			default: nxt.phys = address;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage register; the valid bit is the only reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/mmad_match.sv =====
// Second stage: compares the physical address against every allowed window.
module mmad_match
	import mmad_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  align_t in_data,
	output logic   valid_s2,
	output match_t data_s2,
	input  logic   out_ready
);

	match_t                 nxt;
	logic [NUM_WINDOWS-1:0] allowed;

	// One subtract and compare per window, gated by the kind's window set.
	always_comb begin
		allowed       = kind_windows(in_data.kind);
		nxt.phys      = in_data.phys;
		nxt.wdata     = in_data.wdata;
		nxt.unaligned = in_data.unaligned;
		for (int t = 0; t < NUM_WINDOWS; t++) begin
			nxt.hit[t] = allowed[t] && ((in_data.phys - WIN_START[t]) < WIN_LEN[t]);
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/mmad_resolve.sv =====
// Third stage: picks the target, forms the offset and applies per-target checks.
module mmad_resolve
	import mmad_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  match_t  in_data,
	output logic    valid_s3,
	output result_t data_s3,
	input  logic    out_ready
);

	result_t     nxt;
	logic [3:0]  tgt;
	logic [20:0] start_lo;
	logic [20:0] off;
	logic [3:0]  minor;
	logic [2:0]  grp;
	logic        found;
	logic        dma_ok;

	// Encode the matched window; windows do not overlap.
	always_comb begin
		tgt      = TGT_BIOS;
		start_lo = '0;
		for (int t = NUM_WINDOWS - 1; t >= 0; t--) begin
			if (in_data.hit[t]) begin
				tgt      = 4'(t);
				start_lo = WIN_START[t][20:0];
			end
		end
		found  = |in_data.hit;
		off    = in_data.phys[20:0] - start_lo;
		minor  = off[3:0];
		grp    = off[6:4];
		dma_ok = ((grp != 3'd7) && ((minor == 4'd0) || (minor == 4'd4) || (minor == 4'd8))) ||
			((grp == 3'd7) && ((minor == 4'd0) || (minor == 4'd4)));
	end

	// Result fields and status.
	always_comb begin
		nxt = '0;
		if (in_data.unaligned) begin
			nxt.status = ST_UNALIGNED;
		end else if (!found) begin
			nxt.status = ST_UNMAPPED;
		end else begin
			nxt.target        = tgt;
			nxt.window_offset = off;
			nxt.status        = ST_OK;
			if (tgt == TGT_DMA) begin
				nxt.dma_group = grp;
				if (dma_ok) begin
					nxt.sub_register = minor[3:2];
				end else begin
					nxt.status = ST_BADSUB;
				end
			end else if (tgt == TGT_GPU) begin
				if ((off == 21'd0) || (off == 21'd4)) begin
					nxt.sub_register = off[3:2];
				end else begin
					nxt.status = ST_BADSUB;
				end
			end else if (tgt == TGT_TIMERS) begin
				nxt.absorbed = 1'b1;
			end else if (tgt == TGT_EXP1) begin
				nxt.absorbed      = 1'b1;
				nxt.constant_data = EXP1_READ_VALUE;
			end else if ((tgt == TGT_EXP2) || (tgt == TGT_RAMSIZE) ||
				(tgt == TGT_CACHECTL)) begin
				nxt.absorbed = 1'b1;
			end else if (tgt == TGT_MEMCTL) begin
				if (((off == 21'd0) && (in_data.wdata != MEMCTL_BASE_EXP1)) ||
					((off == 21'd4) && (in_data.wdata != MEMCTL_BASE_EXP2))) begin
					nxt.status = ST_BADBASE;
				end else begin
					nxt.absorbed = 1'b1;
				end
			end
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	// Output register; holds its transaction while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/memory_map_address_decoder_core.sv =====
// Top level of the bus address decoder: three pipeline stages on stream ports.
// An accepted input transaction passes through the align, match and resolve stage
// registers, in that order, before its result is valid on the output.
// Throughput: one access per cycle while the output is not stalled; each stage register
// advances when it is empty or the next stage takes its content, so a stall loses nothing.
// Reset (arst_n low) clears the stage valid bits only; data registers keep
// whatever they hold, and the block accepts input in the first cycle after.
module memory_map_address_decoder_core
	import mmad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [63:0]            s_axis_tdata,  // address[31:0], write_data[63:32]
	input  logic [2:0]             s_axis_tuser,  // func[2:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // target[3:0], window_offset[24:4],
	                                              // dma_group[27:25], sub_register[29:28],
	                                              // absorbed[30], constant_data[38:31],
	                                              // status[41:39], zero fill above
);

	logic    valid_s1;
	logic    valid_s2;
	logic    ready_s2;
	logic    ready_s3;
	align_t  data_s1;
	match_t  data_s2;
	result_t data_s3;

	// Alignment and segment stage.
	mmad_align u_align (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.func       (s_axis_tuser),
		.address    (s_axis_tdata[31:0]),
		.write_data (s_axis_tdata[63:32]),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.out_ready  (ready_s2)
	);

	// Window match stage.
	mmad_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s2),
		.in_data   (data_s1),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.out_ready (ready_s3)
	);

	// Target resolve and output stage.
	mmad_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (ready_s3),
		.in_data   (data_s2),
		.valid_s3  (m_axis_tvalid),
		.data_s3   (data_s3),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = OUT_TDATA_W'(data_s3);

endmodule

// ===== hw/rtl/mmad_checker.sv =====
// Port-level checker for the address decoder and its bind to the top level.
module mmad_checker
	import mmad_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	result_t res;

	assign res = m_axis_tdata[RESULT_W-1:0];

	// A stalled result transaction stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Unaligned and unmapped accesses carry no target or offset.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((res.status == ST_UNALIGNED) || (res.status == ST_UNMAPPED))
		|-> (res.target == TGT_BIOS) && (res.window_offset == '0) && !res.absorbed)
		else $error("failed access reports a target");

	// Only a clean access can be absorbed.
	a_absorb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.absorbed |-> (res.status == ST_OK))
		else $error("absorbed access with error status");

	// A nonzero constant read only comes from an absorbed expansion-1 load.
	a_const: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.constant_data != '0)
		|-> res.absorbed && (res.target == TGT_EXP1))
		else $error("constant data outside expansion 1");

	// A bad sub-register is reported only for DMA and GPU windows.
	a_badsub: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.status == ST_BADSUB)
		|-> (res.target == TGT_DMA) || (res.target == TGT_GPU))
		else $error("bad sub-register on wrong target");

endmodule

bind memory_map_address_decoder_core mmad_checker u_mmad_checker (.*);
